// ===== hdl/srac_pkg.sv =====
// ----------------------------------------------------------------------------
// Sail and rudder actuator command package
// Shared constants, register indexes and pipeline types for the sail winch
// bang-bang controller and the rudder pulse mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package srac_pkg;

  // Width of the time stamps that take part in the age compare.
  localparam int TimeBits = 32;

  // Angles are in tenths of a degree.
  localparam int AngleFull = 3600;
  localparam int AngleHalf = 1800;

  // Rudder mapping: floor(rudder * 8 / 9). The product is biased by 9 * 1024
  // so that the division works on a nonnegative value, and the division by
  // nine is a multiply by ceil(2^18 / 9) followed by a shift.
  localparam int RudBias    = 1024;
  localparam int Div9Recip  = 29128;
  localparam int Div9Shift  = 18;
  localparam int QuoBits    = 11;
  localparam int PulseMax   = 4095;

  // Configuration register indexes.
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgSailCenter   = 3'd0,
    CfgDeadBand     = 3'd1,
    CfgMotorFull    = 3'd2,
    CfgRadioTimeout = 3'd3,
    CfgCompTimeout  = 3'd4,
    CfgRudderCenter = 3'd5
  } srac_cfg_e;

  // Values carried from the first compute stage to the result stage.
  typedef struct packed {
    logic                 radio_valid;
    logic                 computer_valid;
    logic [11:0]          target;
    logic [11:0]          encoder;
    logic [QuoBits-1:0]   rudder_quo;
  } srac_mid_t;

endpackage

`default_nettype wire

// ===== hdl/sail_rudder_actuator_command_top.sv =====
// ----------------------------------------------------------------------------
// Sail rudder actuator command
// Per control tick: checks freshness of the radio and onboard computer
// commands, picks the sail and rudder targets, wraps the sail error, applies
// a deadband to choose the motor drive and maps the rudder angle to a pulse.
// ----------------------------------------------------------------------------
// A tick is carried through the input, compute and result registers in that
// order before its result appears on the result ports.
// Throughput: one tick per cycle; busy_o is never raised, since every stage
// is a plain pipeline register and the receiver cannot stall.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sail_rudder_actuator_command_top
  import srac_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  // Configuration write channel
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,

  // Tick command
  input  wire logic                   start_i,
  output      logic                   busy_o,
  input  wire logic [31:0]            now_ms_i,
  input  wire logic                   radio_seen_i,
  input  wire logic [31:0]            radio_time_ms_i,
  input  wire logic signed [11:0]     radio_sail_i,
  input  wire logic signed [10:0]     radio_rudder_i,
  input  wire logic                   computer_seen_i,
  input  wire logic [31:0]            computer_time_ms_i,
  input  wire logic signed [11:0]     computer_sail_i,
  input  wire logic signed [10:0]     computer_rudder_i,
  input  wire logic [11:0]            encoder_angle_i,

  // Result
  output      logic                   done_o,
  output      logic [15:0]            drive_forward_o,
  output      logic [15:0]            drive_reverse_o,
  output      logic [11:0]            rudder_pulse_o,
  output      logic signed [11:0]     sail_error_o,
  output      logic                   radio_valid_o,
  output      logic                   computer_valid_o
);

  // Configuration registers.
  logic [11:0] sail_center_q;
  logic [10:0] dead_band_q;
  logic [15:0] drive_cmp_q;
  logic [15:0] radio_timeout_q;
  logic [15:0] comp_timeout_q;
  logic [11:0] servo_mid_q;

  // Every write transfer is taken at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sail_center_q   <= 12'd1800;
      dead_band_q     <= 11'd200;
      drive_cmp_q     <= 16'd12800;
      radio_timeout_q <= 16'd2000;
      comp_timeout_q  <= 16'd10000;
      servo_mid_q     <= 12'd1370;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSailCenter:   sail_center_q   <= cfg_data_i[11:0];
        CfgDeadBand:     dead_band_q     <= cfg_data_i[10:0];
        CfgMotorFull:    drive_cmp_q     <= cfg_data_i;
        CfgRadioTimeout: radio_timeout_q <= cfg_data_i;
        CfgCompTimeout:  comp_timeout_q  <= cfg_data_i;
        CfgRudderCenter: servo_mid_q     <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so a tick is taken in every cycle.
  assign busy_o = 1'b0;

  // Input register.
  logic                in_vld_q;
  logic [31:0]         now_q;
  logic                r_seen_q;
  logic [31:0]         r_time_q;
  logic signed [11:0]  r_sail_q;
  logic signed [10:0]  r_rud_q;
  logic                c_seen_q;
  logic [31:0]         c_time_q;
  logic signed [11:0]  c_sail_q;
  logic signed [10:0]  c_rud_q;
  logic [11:0]         enc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      now_q    <= now_ms_i;
      r_seen_q <= radio_seen_i;
      r_time_q <= radio_time_ms_i;
      r_sail_q <= radio_sail_i;
      r_rud_q  <= radio_rudder_i;
      c_seen_q <= computer_seen_i;
      c_time_q <= computer_time_ms_i;
      c_sail_q <= computer_sail_i;
      c_rud_q  <= computer_rudder_i;
      enc_q    <= encoder_angle_i;
    end
  end

  // Stage one: freshness of each source. The age wraps modulo 2^TimeBits.
  logic [TimeBits-1:0] r_age;
  logic [TimeBits-1:0] c_age;
  logic                r_valid;
  logic                c_valid;

  always_comb begin
    r_age   = now_q[TimeBits-1:0] - r_time_q[TimeBits-1:0];
    c_age   = now_q[TimeBits-1:0] - c_time_q[TimeBits-1:0];
    r_valid = r_seen_q && (r_age < TimeBits'(radio_timeout_q));
    c_valid = c_seen_q && (c_age < TimeBits'(comp_timeout_q));
  end

  // Source select: if both are fresh the radio wins unless its value is zero.
  logic signed [11:0] sail_sel;
  logic signed [10:0] rud_sel;

  always_comb begin
    if (r_valid && c_valid) begin
      sail_sel = (r_sail_q != 12'sd0) ? r_sail_q : c_sail_q;
      rud_sel  = (r_rud_q != 11'sd0) ? r_rud_q : c_rud_q;
    end else if (r_valid) begin
      sail_sel = r_sail_q;
      rud_sel  = r_rud_q;
    end else if (c_valid) begin
      sail_sel = c_sail_q;
      rud_sel  = c_rud_q;
    end else begin
      sail_sel = 12'sd0;
      rud_sel  = 11'sd0;
    end
  end

  // Sail target wrapped into one turn; the sum stays within one turn of range.
  logic signed [13:0] tgt_sum;
  logic signed [13:0] tgt_wrap;

  always_comb begin
    tgt_sum = $signed({2'b00, sail_center_q}) + 14'(sail_sel);
    if (tgt_sum < 14'sd0) begin
      tgt_wrap = tgt_sum + 14'(AngleFull);
    end else if (tgt_sum >= 14'(AngleFull)) begin
      tgt_wrap = tgt_sum - 14'(AngleFull);
    end else begin
      tgt_wrap = tgt_sum;
    end
  end

  // Rudder angle times eight, biased positive, divided by nine.
  logic [15:0] rud_biased;
  logic [30:0] rud_prod;

  always_comb begin
    rud_biased = 16'($signed({rud_sel, 3'b000}) + 16'(9 * RudBias));
    rud_prod   = 31'(rud_biased) * 31'(Div9Recip);
  end

  // Compute register.
  logic      mid_vld_q;
  srac_mid_t mid_q;
  srac_mid_t mid_d;

  always_comb begin
    mid_d.radio_valid    = r_valid;
    mid_d.computer_valid = c_valid;
    mid_d.target         = tgt_wrap[11:0];
    mid_d.encoder        = enc_q;
    mid_d.rudder_quo     = rud_prod[Div9Shift +: QuoBits];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
    end else begin
      mid_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      mid_q <= mid_d;
    end
  end

  // Stage two: error wrapped into half a turn either way.
  logic signed [12:0] err_raw;
  logic signed [12:0] err_wrap;
  logic signed [12:0] band;

  always_comb begin
    err_raw = $signed({1'b0, mid_q.target}) - $signed({1'b0, mid_q.encoder});
    if (err_raw > 13'(AngleHalf)) begin
      err_wrap = err_raw - 13'(AngleFull);
    end else if (err_raw < -13'(AngleHalf)) begin
      err_wrap = err_raw + 13'(AngleFull);
    end else begin
      err_wrap = err_raw;
    end
    band = $signed({2'b00, dead_band_q});
  end

  // Deadband drive decision; an error on the band edge leaves the motor off.
  logic [15:0] fwd_d;
  logic [15:0] rev_d;

  always_comb begin
    fwd_d = 16'd0;
    rev_d = 16'd0;
    if (err_wrap > band) begin
      fwd_d = drive_cmp_q;
    end else if (err_wrap < -band) begin
      rev_d = drive_cmp_q;
    end
  end

  // Rudder pulse: center plus the floored quotient, saturated.
  logic signed [13:0] pulse_sum;
  logic [11:0]        pulse_d;

  always_comb begin
    pulse_sum = $signed({2'b00, servo_mid_q}) + $signed({3'b000, mid_q.rudder_quo})
              - 14'(RudBias);
    if (pulse_sum < 14'sd0) begin
      pulse_d = 12'd0;
    end else if (pulse_sum > 14'(PulseMax)) begin
      pulse_d = 12'(PulseMax);
    end else begin
      pulse_d = pulse_sum[11:0];
    end
  end

  // Result register.
  logic               done_q;
  logic [15:0]        fwd_q;
  logic [15:0]        rev_q;
  logic [11:0]        pulse_q;
  logic signed [11:0] err_q;
  logic               rv_q;
  logic               cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mid_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_vld_q) begin
      fwd_q   <= fwd_d;
      rev_q   <= rev_d;
      pulse_q <= pulse_d;
      err_q   <= err_wrap[11:0];
      rv_q    <= mid_q.radio_valid;
      cv_q    <= mid_q.computer_valid;
    end
  end

  assign done_o           = done_q;
  assign drive_forward_o  = fwd_q;
  assign drive_reverse_o  = rev_q;
  assign rudder_pulse_o   = pulse_q;
  assign sail_error_o     = err_q;
  assign radio_valid_o    = rv_q;
  assign computer_valid_o = cv_q;

  // Checks on the pipeline and the arithmetic.
  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (drive_forward_o == 16'd0 || drive_reverse_o == 16'd0))
    else $error("Both motor channels driven in one result.");

  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 3))
    else $error("Result strobe without a tick transfer three cycles earlier.");

  a_error_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sail_error_o >= -12'sd1800 && sail_error_o <= 12'sd1800))
    else $error("Sail error outside half a turn.");

  a_drive_matches_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && drive_forward_o != 16'd0) |-> (sail_error_o > 12'sd0))
    else $error("Forward drive with a nonpositive sail error.");

endmodule

`default_nettype wire
